@@ hdl/vfc_pkg.sv @@
// Shared types and constants for the view frustum culling test block.
// Used by vfc_cell and view_frustum_culling_test; depends on nothing.

package vfc_pkg;

    // Geometry of the request and the plane registers.
    localparam int COORD_BITS_DEF = 16;
    localparam int PLANE_COUNT    = 6;
    localparam int PLANE_W        = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int FIELD_W        = 16;
    localparam int EXT_W          = 15;

    // Arithmetic widths inside a cell.
    localparam int PROD_W  = 2 * FIELD_W;   // normal times coordinate
    localparam int NSUM_W  = FIELD_W + 2;   // |nx| + |ny| + |nz|
    localparam int TERM_W  = EXT_W + NSUM_W; // extent times normal sum
    localparam int D_SHIFT = 14;            // Q2.14 scale of the normals
    localparam int SUM_W   = PROD_W + 4;    // full signed distance

    // Primitive kinds.
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_CUBE   = 2'd1;
    localparam logic [1:0] KIND_SPHERE = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    // One request travelling down the chain of cells.
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic [EXT_W-1:0]          ext;
        logic                      visible;
    } item_t;

    // Plane register write towards one cell.
    typedef struct packed {
        logic               en;
        logic [PLANE_W-1:0] data;
    } cfg_wr_t;

endpackage

@@ hdl/vfc_cell.sv @@
// One cell of the culling chain: holds a single clip plane and tests each request against it.
// Two register stages, products then signed distance. Depends on vfc_pkg.

module vfc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  vfc_pkg::cfg_wr_t cfg_wr,
    input  vfc_pkg::item_t  up_item,
    input  logic            up_valid,
    output logic            up_ready,
    output vfc_pkg::item_t  dn_item,
    output logic            dn_valid,
    input  logic            dn_ready
);
    import vfc_pkg::*;

    logic [PLANE_W-1:0] plane_reg;

    logic signed [FIELD_W-1:0] nx;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] nd;
    logic signed [FIELD_W:0]   nx_w;
    logic signed [FIELD_W:0]   ny_w;
    logic signed [FIELD_W:0]   nz_w;
    logic [NSUM_W-1:0]         norm_sum;

    logic signed [PROD_W-1:0] a_px_next;
    logic signed [PROD_W-1:0] a_py_next;
    logic signed [PROD_W-1:0] a_pz_next;
    logic [TERM_W-1:0]        a_term_next;

    item_t                    a_item_reg;
    logic signed [PROD_W-1:0] a_px_reg;
    logic signed [PROD_W-1:0] a_py_reg;
    logic signed [PROD_W-1:0] a_pz_reg;
    logic signed [FIELD_W-1:0] a_d_reg;
    logic [TERM_W-1:0]        a_term_reg;
    logic                     va_reg;

    logic signed [SUM_W-1:0] distance;
    item_t                   b_item_next;
    item_t                   b_item_reg;
    logic                    vb_reg;

    logic rdy_a;
    logic rdy_b;

    // Plane register; the user must write it only while the block is idle, the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (cfg_wr.en)
        begin
            plane_reg <= cfg_wr.data;
        end
    end

    assign nx = signed'(plane_reg[15:0]);
    assign ny = signed'(plane_reg[31:16]);
    assign nz = signed'(plane_reg[47:32]);
    assign nd = signed'(plane_reg[63:48]);

    assign nx_w = (FIELD_W + 1)'(nx);
    assign ny_w = (FIELD_W + 1)'(ny);
    assign nz_w = (FIELD_W + 1)'(nz);

    // Stage A: the three normal products and the extent term.
    always_comb
    begin
        norm_sum = NSUM_W'(nx_w[FIELD_W] ? -nx_w : nx_w)
                 + NSUM_W'(ny_w[FIELD_W] ? -ny_w : ny_w)
                 + NSUM_W'(nz_w[FIELD_W] ? -nz_w : nz_w);

        a_px_next = PROD_W'(nx) * PROD_W'(up_item.x);
        a_py_next = PROD_W'(ny) * PROD_W'(up_item.y);
        a_pz_next = PROD_W'(nz) * PROD_W'(up_item.z);

        // Outside when distance plus this term is not positive.
        case (up_item.kind)
            KIND_CUBE:   a_term_next = TERM_W'(up_item.ext) * TERM_W'(norm_sum);
            KIND_SPHERE: a_term_next = TERM_W'(up_item.ext) << D_SHIFT;
            KIND_POINT:  a_term_next = '0;
            default:     a_term_next = '0;
        endcase
    end

    // Stage B: signed distance and the running visibility flag.
    always_comb
    begin
        distance = SUM_W'(a_px_reg) + SUM_W'(a_py_reg) + SUM_W'(a_pz_reg)
                 + (SUM_W'(a_d_reg) <<< D_SHIFT)
                 + SUM_W'(signed'({1'b0, a_term_reg}));
        b_item_next         = a_item_reg;
        b_item_next.visible = a_item_reg.visible && !distance[SUM_W-1] && (distance != '0);
    end

    assign rdy_b    = !vb_reg || dn_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign up_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= up_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && up_valid)
        begin
            a_item_reg <= up_item;
            a_px_reg   <= a_px_next;
            a_py_reg   <= a_py_next;
            a_pz_reg   <= a_pz_next;
            a_d_reg    <= nd;
            a_term_reg <= a_term_next;
        end
        if (rdy_b && va_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign dn_item  = b_item_reg;
    assign dn_valid = vb_reg;

    // The cell only pushes back when both of its stages are occupied.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !up_ready |-> (va_reg && vb_reg))
        else $error("cell stalls upstream with a free stage");

    // A request leaving stage A must land in stage B.
    a_to_b_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (va_reg && rdy_b) |=> vb_reg)
        else $error("request lost between cell stages");

endmodule

@@ hdl/view_frustum_culling_test.sv @@
// Top level of the six-plane view frustum culling test.
// Chains one vfc_cell per clip plane; depends on vfc_pkg and vfc_cell.
//
// Usage. A request (req_type, pos_x/y/z, extent) is taken at a rising edge
// where in_valid is high and in_stall is low. It is a point, an axis-aligned
// cube (centre and half-size) or a sphere (centre and radius); the reserved
// kind always answers outside. The answer appears on inside_res with
// out_valid and is taken at an edge where out_valid is high and out_stall low.
// Plane registers are written through the cfg channel (cfg_index 0..5 =
// right, left, bottom, top, far, near; other indices are ignored), which is
// always ready. Write them only while no request is in flight.
// Timing. Each of the six cells holds one plane and has two register stages,
// and a request passes stage A then stage B of each cell in turn, first cell
// to last, before its answer is valid on the output. A new request can enter
// every cycle while in_stall is low. The last cell's second stage is the
// output register. When the receiver stalls, requests keep entering until
// every stage is full; in_stall then rises, and it falls as soon as a slot
// frees. Reset empties all stages and clears all six planes to zero; with
// zero planes only a sphere of non-zero radius is reported inside.

module view_frustum_culling_test #(
    parameter int COORD_BITS = vfc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic signed [vfc_pkg::FIELD_W-1:0] pos_x,
    input  logic signed [vfc_pkg::FIELD_W-1:0] pos_y,
    input  logic signed [vfc_pkg::FIELD_W-1:0] pos_z,
    input  logic [vfc_pkg::EXT_W-1:0]         extent,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              inside_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vfc_pkg::PLANE_W-1:0]       cfg_data
);
    import vfc_pkg::*;

    // Coordinates carry only their low CW bits; the rest are a sign extension.
    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    item_t   node_item  [PLANE_COUNT+1];
    logic    node_valid [PLANE_COUNT+1];
    logic    node_ready [PLANE_COUNT+1];
    cfg_wr_t cell_cfg   [PLANE_COUNT];

    // Entry of the chain: the incoming request, with the reserved kind
    // already marked outside.
    always_comb
    begin
        node_item[0].kind    = req_type;
        node_item[0].x       = FIELD_W'(signed'(pos_x[CW-1:0]));
        node_item[0].y       = FIELD_W'(signed'(pos_y[CW-1:0]));
        node_item[0].z       = FIELD_W'(signed'(pos_z[CW-1:0]));
        node_item[0].ext     = extent;
        node_item[0].visible = (req_type != KIND_RSVD);
    end

    assign node_valid[0] = in_valid;
    assign in_stall      = !node_ready[0];

    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < PLANE_COUNT; i++)
    begin : g_cell
        assign cell_cfg[i].en   = cfg_valid && cfg_ready && (cfg_index == CFG_IDX_W'(i));
        assign cell_cfg[i].data = cfg_data;

        vfc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg_wr   (cell_cfg[i]),
            .up_item  (node_item[i]),
            .up_valid (node_valid[i]),
            .up_ready (node_ready[i]),
            .dn_item  (node_item[i+1]),
            .dn_valid (node_valid[i+1]),
            .dn_ready (node_ready[i+1])
        );
    end

    // The last cell's output stage drives the result channel directly.
    assign out_valid                = node_valid[PLANE_COUNT];
    assign inside_res               = node_item[PLANE_COUNT].visible;
    assign node_ready[PLANE_COUNT]  = !out_stall;

    // Requests are only refused when a finished result is being held back.
    a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output is free");

endmodule
